// ===== rtl/core/ipc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types and constants of the interrupt priority controller.
// ----------------------------------------------------------------------------
package ipc_pkg;

  // Item kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_EXT   = 2'd2;
  localparam logic [1:0] KIND_INT   = 2'd3;

  // Bus access sizes
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;
  localparam logic [1:0] SIZE_BAD   = 2'd3;

  // Register offsets
  localparam logic [7:0] OFF_CTRL  = 8'h00;
  localparam logic [7:0] OFF_PRI_A = 8'h04;
  localparam logic [7:0] OFF_PRI_B = 8'h08;
  localparam logic [7:0] OFF_PRI_C = 8'h0c;

  // Internal sources
  localparam logic [3:0] SRC_TMU0  = 4'd0;
  localparam logic [3:0] SRC_TMU1  = 4'd1;
  localparam logic [3:0] SRC_TMU2  = 4'd2;
  localparam logic [3:0] SRC_RTC   = 4'd3;
  localparam logic [3:0] SRC_WDT   = 4'd4;
  localparam logic [3:0] SRC_REF   = 4'd5;
  localparam logic [3:0] SRC_SCI   = 4'd6;
  localparam logic [3:0] SRC_GPIO  = 4'd7;
  localparam logic [3:0] SRC_DMA   = 4'd8;
  localparam logic [3:0] SRC_SCIF  = 4'd9;
  localparam logic [3:0] SRC_DEBUG = 4'd10;

  // Status register bits
  localparam int unsigned SR_BL_POS = 28;
  localparam logic [31:0] SR_TAKEN_SET = 32'h7000_0000;  // MD, RB, BL
  localparam logic [31:0] VECTOR_OFFSET = 32'h0000_0600;
  localparam logic [3:0]  LEVEL_TOP = 4'hf;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
    logic [3:0]  ext_level;
    logic [3:0]  source_id;
    logic [11:0] event_code;
    logic [31:0] cpu_status;
    logic [31:0] current_pc;
    logic [31:0] vector_base;
  } in_word_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        accepted;
    logic [31:0] next_status;
    logic [31:0] next_pc;
    logic [31:0] saved_pc;
    logic [31:0] saved_status;
    logic [11:0] event_out;
  } out_word_t;

  // Register bus access toward the register file
  typedef struct packed {
    logic        wr_en;
    logic [7:0]  offset;
    logic [1:0]  size;
    logic [31:0] wdata;
  } reg_acc_t;

  // Priority lookup of an internal source
  typedef struct packed {
    logic       known;
    logic [3:0] level;
  } src_lvl_t;

endpackage

// ===== rtl/core/ipc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_in_if
// Input word channel: bus accesses and interrupt requests.
// ----------------------------------------------------------------------------
interface ipc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  reg_offset;
  logic [1:0]  access_size;
  logic [31:0] write_data;
  logic [3:0]  ext_level;
  logic [3:0]  source_id;
  logic [11:0] event_code;
  logic [31:0] cpu_status;
  logic [31:0] current_pc;
  logic [31:0] vector_base;

  modport source (
    output valid, kind, reg_offset, access_size, write_data, ext_level,
           source_id, event_code, cpu_status, current_pc, vector_base,
    input  ready
  );

  modport sink (
    input  valid, kind, reg_offset, access_size, write_data, ext_level,
           source_id, event_code, cpu_status, current_pc, vector_base,
    output ready
  );
endinterface

// ===== rtl/core/ipc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_out_if
// Result word channel: read data and interrupt acceptance values.
// ----------------------------------------------------------------------------
interface ipc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        accepted;
  logic [31:0] next_status;
  logic [31:0] next_pc;
  logic [31:0] saved_pc;
  logic [31:0] saved_status;
  logic [11:0] event_out;

  modport source (
    output valid, read_data, accepted, next_status, next_pc, saved_pc,
           saved_status, event_out,
    input  ready
  );

  modport sink (
    input  valid, read_data, accepted, next_status, next_pc, saved_pc,
           saved_status, event_out,
    output ready
  );
endinterface

// ===== rtl/core/interrupt_priority_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_priority_controller
// Interrupt priority controller with bus-accessible priority registers.
//
// Channels: in_word takes one word per valid/ready handshake, either a
// register read or write (offset 0 control, 4/8/12 priority A/B/C) or an
// external or internal interrupt request with the processor's status, pc
// and vector base. out_word returns exactly one result word per input word,
// in order: read data, the accept flag and the values the processor loads
// and saves when the request is taken.
// Path: the input word is held in the input register and its result word in
// the result register, which drives out_word. Throughput: one word per cycle
// while out_word.ready stays high, set by the single pass through the
// register file lookup and the mask compare.
// Register writes take effect for the very next word.
// Reset: synchronous, active low; the control and priority registers clear
// to zero and both pipeline stages empty.
// Stall: when out_word.ready is low the result holds; the input register
// still fills, and in_word.ready drops only while both stages are full.
// ----------------------------------------------------------------------------
module interrupt_priority_controller (
  input  logic      clk,
  input  logic      rst_n,
  ipc_in_if.sink    in_word,
  ipc_out_if.source out_word
);
  import ipc_pkg::*;

  in_word_t  in_w;
  in_word_t  s1_r;
  logic      s1_v_r, s1_v_nxt;
  out_word_t s2_r;
  logic      s2_v_r, s2_v_nxt;
  out_word_t eval_w;
  reg_acc_t  acc;
  src_lvl_t  src_lvl;
  logic [15:0] rdata;
  logic      s2_open;
  logic      s1_adv;
  logic      in_take;

  // Gather the input word
  assign in_w.kind        = in_word.kind;
  assign in_w.reg_offset  = in_word.reg_offset;
  assign in_w.access_size = in_word.access_size;
  assign in_w.write_data  = in_word.write_data;
  assign in_w.ext_level   = in_word.ext_level;
  assign in_w.source_id   = in_word.source_id;
  assign in_w.event_code  = in_word.event_code;
  assign in_w.cpu_status  = in_word.cpu_status;
  assign in_w.current_pc  = in_word.current_pc;
  assign in_w.vector_base = in_word.vector_base;

  // Pipeline flow control
  assign s2_open       = !s2_v_r || out_word.ready;
  assign s1_adv        = s1_v_r && s2_open;
  assign in_word.ready = !s1_v_r || s2_open;
  assign in_take       = in_word.valid && in_word.ready;

  assign s1_v_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign s2_v_nxt = s1_adv ? 1'b1 : (out_word.ready ? 1'b0 : s2_v_r);

  // Register access commits only when the word moves on
  assign acc.wr_en  = s1_adv && (s1_r.kind == KIND_WRITE);
  assign acc.offset = s1_r.reg_offset;
  assign acc.size   = s1_r.access_size;
  assign acc.wdata  = s1_r.write_data;

  ipc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .source_id (s1_r.source_id),
    .rdata     (rdata),
    .src_lvl   (src_lvl)
  );

  ipc_eval u_eval (
    .in_w    (s1_r),
    .rdata   (rdata),
    .src_lvl (src_lvl),
    .out_w   (eval_w)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_r <= in_w;
    end
    if (s1_adv) begin
      s2_r <= eval_w;
    end
  end

  // Drive the result channel
  assign out_word.valid        = s2_v_r;
  assign out_word.read_data    = s2_r.read_data;
  assign out_word.accepted     = s2_r.accepted;
  assign out_word.next_status  = s2_r.next_status;
  assign out_word.next_pc      = s2_r.next_pc;
  assign out_word.saved_pc     = s2_r.saved_pc;
  assign out_word.saved_status = s2_r.saved_status;
  assign out_word.event_out    = s2_r.event_out;
endmodule

// ===== rtl/core/ipc_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_regs
// Control and priority registers with sized bus access and source lookup.
// ----------------------------------------------------------------------------
module ipc_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  ipc_pkg::reg_acc_t acc,
  input  logic [3:0]        source_id,
  output logic [15:0]       rdata,
  output ipc_pkg::src_lvl_t src_lvl
);
  import ipc_pkg::*;

  logic [15:0] ctrl_r, ctrl_nxt;
  logic [15:0] pri_a_r, pri_a_nxt;
  logic [15:0] pri_b_r, pri_b_nxt;
  logic [15:0] pri_c_r, pri_c_nxt;
  logic [15:0] sel_val;
  logic        sel_hit;
  logic [15:0] wr_val;
  logic        wr_ok;

  // Decode the addressed register
  always_comb begin
    sel_hit = 1'b1;
    sel_val = '0;
    unique case (acc.offset)
      OFF_CTRL:  sel_val = ctrl_r;
      OFF_PRI_A: sel_val = pri_a_r;
      OFF_PRI_B: sel_val = pri_b_r;
      OFF_PRI_C: sel_val = pri_c_r;
      default:   sel_hit = 1'b0;
    endcase
  end

  // Sized read and write merge
  always_comb begin
    rdata  = '0;
    wr_val = sel_val;
    wr_ok  = 1'b0;
    unique case (acc.size)
      SIZE_BYTE: begin
        rdata  = {8'h00, sel_val[7:0]};
        wr_val = {sel_val[15:8], acc.wdata[7:0]};
        wr_ok  = 1'b1;
      end
      SIZE_WORD, SIZE_DWORD: begin
        rdata  = sel_val;
        wr_val = acc.wdata[15:0];
        wr_ok  = 1'b1;
      end
      default: begin
        rdata = '0;
      end
    endcase
    if (!sel_hit) begin
      rdata = '0;
      wr_ok = 1'b0;
    end
  end

  // Update the addressed register
  always_comb begin
    ctrl_nxt  = ctrl_r;
    pri_a_nxt = pri_a_r;
    pri_b_nxt = pri_b_r;
    pri_c_nxt = pri_c_r;
    if (acc.wr_en && wr_ok) begin
      unique case (acc.offset)
        OFF_CTRL:  ctrl_nxt  = wr_val;
        OFF_PRI_A: pri_a_nxt = wr_val;
        OFF_PRI_B: pri_b_nxt = wr_val;
        OFF_PRI_C: pri_c_nxt = wr_val;
        default:   ctrl_nxt  = ctrl_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      pri_a_r <= '0;
      pri_b_r <= '0;
      pri_c_r <= '0;
    end else begin
      ctrl_r  <= ctrl_nxt;
      pri_a_r <= pri_a_nxt;
      pri_b_r <= pri_b_nxt;
      pri_c_r <= pri_c_nxt;
    end
  end

  // Look up the priority nibble of an internal source
  always_comb begin
    src_lvl.known = 1'b1;
    src_lvl.level = '0;
    unique case (source_id)
      SRC_TMU0:  src_lvl.level = pri_a_r[15:12];
      SRC_TMU1:  src_lvl.level = pri_a_r[11:8];
      SRC_TMU2:  src_lvl.level = pri_a_r[7:4];
      SRC_RTC:   src_lvl.level = pri_a_r[3:0];
      SRC_WDT:   src_lvl.level = pri_b_r[15:12];
      SRC_REF:   src_lvl.level = pri_b_r[11:8];
      SRC_SCI:   src_lvl.level = pri_b_r[7:4];
      SRC_GPIO:  src_lvl.level = pri_c_r[15:12];
      SRC_DMA:   src_lvl.level = pri_c_r[11:8];
      SRC_SCIF:  src_lvl.level = pri_c_r[7:4];
      SRC_DEBUG: src_lvl.level = pri_c_r[3:0];
      default:   src_lvl.known = 1'b0;
    endcase
  end
endmodule

// ===== rtl/core/ipc_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_eval
// Interrupt acceptance decision and result word assembly.
// ----------------------------------------------------------------------------
module ipc_eval (
  input  ipc_pkg::in_word_t  in_w,
  input  logic [15:0]        rdata,
  input  ipc_pkg::src_lvl_t  src_lvl,
  output ipc_pkg::out_word_t out_w
);
  import ipc_pkg::*;

  logic [3:0] mask;
  logic       blocked;
  logic       taken;

  assign mask    = in_w.cpu_status[7:4];
  assign blocked = in_w.cpu_status[SR_BL_POS];

  // Compare the request priority against the status mask
  always_comb begin
    taken = 1'b0;
    unique case (in_w.kind)
      KIND_EXT: taken = !blocked && ((LEVEL_TOP - in_w.ext_level) > mask);
      KIND_INT: taken = !blocked && src_lvl.known && (src_lvl.level > mask);
      default:  taken = 1'b0;
    endcase
  end

  // Assemble the result word
  always_comb begin
    out_w.read_data = (in_w.kind == KIND_READ) ? rdata : 16'h0000;
    out_w.accepted  = taken;
    if (taken) begin
      out_w.next_status  = in_w.cpu_status | SR_TAKEN_SET;
      out_w.next_pc      = in_w.vector_base + VECTOR_OFFSET;
      out_w.saved_pc     = in_w.current_pc;
      out_w.saved_status = in_w.cpu_status;
      out_w.event_out    = in_w.event_code;
    end else begin
      out_w.next_status  = in_w.cpu_status;
      out_w.next_pc      = in_w.current_pc;
      out_w.saved_pc     = '0;
      out_w.saved_status = '0;
      out_w.event_out    = '0;
    end
  end
endmodule

// ===== tb/interrupt_priority_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_priority_controller_tb
// Self-checking bench for the interrupt priority controller.
//
// Sends a short directed sequence and then about 1500 random words. The
// words are register reads and writes at legal and illegal offsets and
// sizes, and external and internal interrupt requests under random masks
// and block bits. A predictor keeps its own copy of the control and
// priority registers. It computes the result word for each accepted input,
// and the monitor checks every field in order. Sender and receiver idle at
// random in three phases, and the sender drains the pipeline at a few
// points.
// ----------------------------------------------------------------------------
module interrupt_priority_controller_tb;
  import ipc_pkg::*;

  localparam int RANDOM_WORDS = 1500;
  localparam int PHASE_LEN    = 520;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES  = 10;

  localparam logic [7:0] REG_OFFS [4] = '{OFF_CTRL, OFF_PRI_A, OFF_PRI_B, OFF_PRI_C};
  localparam logic [7:0] OFF_NONE_HI = 8'hff;
  localparam logic [7:0] OFF_NONE_LO = 8'h10;
  localparam logic [3:0] SRC_NONE_LO = SRC_DEBUG + 4'd1;
  localparam logic [3:0] SRC_NONE_HI = 4'hf;
  localparam logic [31:0] SR_BL      = 32'h1 << SR_BL_POS;

  typedef struct {
    in_word_t w;
    bit       drain;  // hold until every outstanding result has come back
  } pending_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ipc_in_if  in_word ();
  ipc_out_if out_word ();

  interrupt_priority_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .out_word(out_word)
  );

  // Predictor copy of the register file
  logic [15:0] ctrl_reg;
  logic [15:0] pri_a;
  logic [15:0] pri_b;
  logic [15:0] pri_c;

  pending_t  word_q [$];
  out_word_t outcome_q [$];
  in_word_t  cur_word;

  int cycle_cnt = 0;
  int sent_cnt  = 0;
  int recv_cnt  = 0;
  int fail_cnt  = 0;
  int taken_cnt = 0;
  int kind_cnt [4];

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle count, reset release and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    rst_n     <= (cycle_cnt >= 4);
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles: %0d words sent, %0d results received",
               cycle_cnt, sent_cnt, recv_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Idle rate per side: sender light first, then receiver light, then none
  function automatic int idle_pct(bit for_sender);
    if (sent_cnt < PHASE_LEN) return for_sender ? 19 : 86;
    if (sent_cnt < 2 * PHASE_LEN) return for_sender ? 86 : 19;
    return 0;
  endfunction

  // Predict the result word of one input word and update the register copy
  function automatic out_word_t compute_outcome(in_word_t w);
    out_word_t   r;
    logic [15:0] cur;
    logic        hit;
    logic        take;
    logic        known;
    logic [3:0]  lvl;
    logic [3:0]  mask;
    r     = '0;
    hit   = 1'b1;
    take  = 1'b0;
    known = 1'b1;
    lvl   = '0;
    mask  = w.cpu_status[7:4];
    case (w.reg_offset)
      OFF_CTRL:  cur = ctrl_reg;
      OFF_PRI_A: cur = pri_a;
      OFF_PRI_B: cur = pri_b;
      OFF_PRI_C: cur = pri_c;
      default: begin
        cur = '0;
        hit = 1'b0;
      end
    endcase
    kind_cnt[w.kind]++;
    case (w.kind)
      KIND_READ: begin
        if (hit && w.access_size == SIZE_BYTE) r.read_data = {8'h00, cur[7:0]};
        else if (hit && w.access_size != SIZE_BAD) r.read_data = cur;
      end
      KIND_WRITE: begin
        if (hit && w.access_size != SIZE_BAD) begin
          if (w.access_size == SIZE_BYTE) cur = {cur[15:8], w.write_data[7:0]};
          else cur = w.write_data[15:0];
          case (w.reg_offset)
            OFF_CTRL:  ctrl_reg = cur;
            OFF_PRI_A: pri_a = cur;
            OFF_PRI_B: pri_b = cur;
            default:   pri_c = cur;
          endcase
        end
      end
      KIND_EXT: begin
        take = !w.cpu_status[SR_BL_POS] && ((LEVEL_TOP - w.ext_level) > mask);
      end
      default: begin
        case (w.source_id)
          SRC_TMU0:  lvl = pri_a[15:12];
          SRC_TMU1:  lvl = pri_a[11:8];
          SRC_TMU2:  lvl = pri_a[7:4];
          SRC_RTC:   lvl = pri_a[3:0];
          SRC_WDT:   lvl = pri_b[15:12];
          SRC_REF:   lvl = pri_b[11:8];
          SRC_SCI:   lvl = pri_b[7:4];
          SRC_GPIO:  lvl = pri_c[15:12];
          SRC_DMA:   lvl = pri_c[11:8];
          SRC_SCIF:  lvl = pri_c[7:4];
          SRC_DEBUG: lvl = pri_c[3:0];
          default:   known = 1'b0;
        endcase
        take = !w.cpu_status[SR_BL_POS] && known && (lvl > mask);
      end
    endcase
    if (take) begin
      taken_cnt++;
      r.accepted     = 1'b1;
      r.next_status  = w.cpu_status | SR_TAKEN_SET;
      r.next_pc      = w.vector_base + VECTOR_OFFSET;
      r.saved_pc     = w.current_pc;
      r.saved_status = w.cpu_status;
      r.event_out    = w.event_code;
    end else begin
      r.next_status = w.cpu_status;
      r.next_pc     = w.current_pc;
    end
    return r;
  endfunction

  function automatic in_word_t bus_word(logic [1:0] kind, logic [7:0] off,
                                        logic [1:0] size, logic [31:0] data);
    in_word_t w;
    w             = '0;
    w.kind        = kind;
    w.reg_offset  = off;
    w.access_size = size;
    w.write_data  = data;
    w.cpu_status  = $urandom();
    w.current_pc  = $urandom();
    w.vector_base = $urandom();
    w.event_code  = 12'($urandom_range(4095));
    return w;
  endfunction

  function automatic in_word_t irq_word(logic [1:0] kind, logic [3:0] ext,
                                        logic [3:0] src, logic [31:0] status,
                                        logic [31:0] vbr);
    in_word_t w;
    w             = '0;
    w.kind        = kind;
    w.ext_level   = ext;
    w.source_id   = src;
    w.cpu_status  = status;
    w.vector_base = vbr;
    w.current_pc  = $urandom();
    w.event_code  = 12'($urandom_range(4095));
    w.write_data  = $urandom();
    return w;
  endfunction

  // Mostly legal offsets and sizes with random content, some noise
  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 20) w.kind = KIND_READ;
    else if (pick < 45) w.kind = KIND_WRITE;
    else if (pick < 70) w.kind = KIND_EXT;
    else w.kind = KIND_INT;
    if ($urandom_range(99) < 80) w.reg_offset = REG_OFFS[$urandom_range(3)];
    else w.reg_offset = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) w.access_size = SIZE_BAD;
    else w.access_size = 2'($urandom_range(SIZE_DWORD, SIZE_BYTE));
    w.write_data = $urandom();
    w.ext_level  = 4'($urandom_range(15));
    if ($urandom_range(9) == 0) w.source_id = 4'($urandom_range(SRC_NONE_HI, SRC_NONE_LO));
    else w.source_id = 4'($urandom_range(SRC_DEBUG, SRC_TMU0));
    w.event_code = 12'($urandom_range(4095));
    w.cpu_status = $urandom();
    w.cpu_status[SR_BL_POS] = ($urandom_range(6) == 0);
    w.current_pc  = $urandom();
    w.vector_base = $urandom();
    return w;
  endfunction

  task automatic queue_word(in_word_t w, bit drain);
    pending_t p;
    p.w     = w;
    p.drain = drain;
    word_q.push_back(p);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Driver: advance on handshake, insert random gaps, hold for drains
  always @(posedge clk) begin
    pending_t nxt;
    bit       give;
    if (!rst_n) begin
      in_word.valid <= 1'b0;
    end else begin
      if (in_word.valid && in_word.ready) begin
        outcome_q.push_back(compute_outcome(cur_word));
        sent_cnt++;
      end
      if (!in_word.valid || in_word.ready) begin
        give = (word_q.size() != 0) && ($urandom_range(99) >= idle_pct(1'b1));
        if (give && word_q[0].drain && outcome_q.size() != 0) give = 1'b0;
        if (give) begin
          nxt = word_q.pop_front();
          cur_word              = nxt.w;
          in_word.kind        <= nxt.w.kind;
          in_word.reg_offset  <= nxt.w.reg_offset;
          in_word.access_size <= nxt.w.access_size;
          in_word.write_data  <= nxt.w.write_data;
          in_word.ext_level   <= nxt.w.ext_level;
          in_word.source_id   <= nxt.w.source_id;
          in_word.event_code  <= nxt.w.event_code;
          in_word.cpu_status  <= nxt.w.cpu_status;
          in_word.current_pc  <= nxt.w.current_pc;
          in_word.vector_base <= nxt.w.vector_base;
        end
        in_word.valid <= give;
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_word.ready <= 1'b0;
    end else begin
      if (out_word.valid && out_word.ready) begin
        recv_cnt++;
        if (outcome_q.size() == 0) begin
          $error("result word received with no prediction outstanding");
          fail_cnt++;
        end else begin
          want = outcome_q.pop_front();
          check_field("read_data", 32'(want.read_data), 32'(out_word.read_data));
          check_field("accepted", 32'(want.accepted), 32'(out_word.accepted));
          check_field("next_status", want.next_status, out_word.next_status);
          check_field("next_pc", want.next_pc, out_word.next_pc);
          check_field("saved_pc", want.saved_pc, out_word.saved_pc);
          check_field("saved_status", want.saved_status, out_word.saved_status);
          check_field("event_out", 32'(want.event_out), 32'(out_word.event_out));
        end
      end
      out_word.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // Stimulus and end of run
  initial begin
    in_word.valid       = 1'b0;
    in_word.kind        = KIND_READ;
    in_word.reg_offset  = '0;
    in_word.access_size = SIZE_BYTE;
    in_word.write_data  = '0;
    in_word.ext_level   = '0;
    in_word.source_id   = '0;
    in_word.event_code  = '0;
    in_word.cpu_status  = '0;
    in_word.current_pc  = '0;
    in_word.vector_base = '0;
    out_word.ready      = 1'b0;
    cur_word            = '0;
    ctrl_reg            = '0;
    pri_a               = '0;
    pri_b               = '0;
    pri_c               = '0;
    kind_cnt            = '{default: 0};

    // Register access: sizes, byte merge, bad size, unknown offsets
    queue_word(bus_word(KIND_READ, OFF_CTRL, SIZE_DWORD, '0), 1'b0);
    queue_word(bus_word(KIND_WRITE, OFF_CTRL, SIZE_DWORD, 32'hffff_ffff), 1'b0);
    queue_word(bus_word(KIND_READ, OFF_CTRL, SIZE_BYTE, '0), 1'b0);
    queue_word(bus_word(KIND_WRITE, OFF_CTRL, SIZE_BYTE, 32'h0000_0012), 1'b0);
    queue_word(bus_word(KIND_READ, OFF_CTRL, SIZE_WORD, '0), 1'b0);
    queue_word(bus_word(KIND_WRITE, OFF_CTRL, SIZE_BAD, '0), 1'b0);
    queue_word(bus_word(KIND_READ, OFF_CTRL, SIZE_BAD, '0), 1'b0);
    queue_word(bus_word(KIND_WRITE, OFF_NONE_HI, SIZE_DWORD, 32'h0000_5555), 1'b0);
    queue_word(bus_word(KIND_READ, OFF_NONE_LO, SIZE_WORD, '0), 1'b0);
    queue_word(bus_word(KIND_WRITE, OFF_PRI_A, SIZE_WORD, 32'h0000_f1e2), 1'b0);
    queue_word(bus_word(KIND_WRITE, OFF_PRI_B, SIZE_DWORD, 32'habcd_9870), 1'b0);
    queue_word(bus_word(KIND_WRITE, OFF_PRI_C, SIZE_WORD, 32'h0000_3c0f), 1'b0);
    queue_word(bus_word(KIND_READ, OFF_PRI_A, SIZE_BYTE, '0), 1'b0);
    queue_word(bus_word(KIND_READ, OFF_PRI_B, SIZE_DWORD, '0), 1'b0);
    queue_word(bus_word(KIND_READ, OFF_PRI_C, SIZE_WORD, '0), 1'b0);

    // External requests: mask edges, block bit, vector wrap
    queue_word(irq_word(KIND_EXT, 4'd0, SRC_TMU0, 32'h0000_00e0, 32'hffff_fc00), 1'b0);
    queue_word(irq_word(KIND_EXT, 4'd0, SRC_TMU0, 32'h0000_00f0, 32'hffff_fc00), 1'b0);
    queue_word(irq_word(KIND_EXT, 4'd15, SRC_TMU0, 32'h0000_0000, 32'h0), 1'b0);
    queue_word(irq_word(KIND_EXT, 4'd0, SRC_TMU0, SR_BL, 32'h0), 1'b0);

    // Internal requests: top and zero levels, unknown sources, block bit
    queue_word(irq_word(KIND_INT, 4'd0, SRC_TMU0, 32'h0000_00e0, 32'hffff_ffff), 1'b0);
    queue_word(irq_word(KIND_INT, 4'd0, SRC_DEBUG, 32'h8fff_ffe0 & ~SR_BL, 32'h0), 1'b0);
    queue_word(irq_word(KIND_INT, 4'd0, SRC_SCIF, 32'h0000_0000, 32'h0), 1'b0);
    queue_word(irq_word(KIND_INT, 4'd0, SRC_NONE_LO, 32'h0000_0000, 32'h0), 1'b0);
    queue_word(irq_word(KIND_INT, 4'd0, SRC_NONE_HI, 32'h0000_0000, 32'h0), 1'b0);
    queue_word(irq_word(KIND_INT, 4'd0, SRC_TMU0, 32'hffff_ff0f, 32'h0), 1'b0);

    // Random part, with a drain after the directed words and twice more
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      queue_word(random_word(), (i == 0) || (i == 700) || (i == 1300));
    end

    // Wait for the last word to go out and every result to come back
    do @(negedge clk);
    while (word_q.size() != 0 || in_word.valid || outcome_q.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Checked %0d result words: %0d reads, %0d writes, %0d external requests,",
             recv_cnt, kind_cnt[KIND_READ], kind_cnt[KIND_WRITE], kind_cnt[KIND_EXT]);
    $display("%0d internal requests, %0d requests taken, %0d mismatches.",
             kind_cnt[KIND_INT], taken_cnt, fail_cnt);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
